[rtl/core/glc_pkg.sv]
// ----------------------------------------------------------------------------
// glc_pkg
// Shared constants, codes and control/status types of the guidance lightbar
// controller core.
// ----------------------------------------------------------------------------
package glc_pkg;

	// Bar geometry
	localparam int NUM_PIXELS = 35;
	localparam int PIX_W      = 6;
	localparam int CENTRE     = (NUM_PIXELS - 1) / 2;
	localparam int LVL_W      = $clog2(CENTRE + 1);
	localparam logic [PIX_W-1:0] LAST_PIX   = PIX_W'(NUM_PIXELS - 1);
	localparam logic [PIX_W-1:0] CENTRE_PIX = PIX_W'(CENTRE);

	// Event codes
	localparam logic [1:0] OP_LINK   = 2'd0;
	localparam logic [1:0] OP_MSG    = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_BUTTON = 2'd3;

	// Status codes
	localparam logic [1:0] MODE_NO_LINK  = 2'd0;
	localparam logic [1:0] MODE_NO_DATA  = 2'd1;
	localparam logic [1:0] MODE_AUTO_OFF = 2'd2;
	localparam logic [1:0] MODE_GUIDING  = 2'd3;

	// Pixel colour codes
	localparam logic [2:0] COL_BLACK  = 3'd0;
	localparam logic [2:0] COL_RED    = 3'd1;
	localparam logic [2:0] COL_GREEN  = 3'd2;
	localparam logic [2:0] COL_BLUE   = 3'd3;
	localparam logic [2:0] COL_YELLOW = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] CFG_UNITS_PER_PIXEL = 3'd0;
	localparam logic [2:0] CFG_MSG_TIMEOUT     = 3'd1;
	localparam logic [2:0] CFG_REFRESH_PERIOD  = 3'd2;
	localparam logic [2:0] CFG_BRIGHT_STEP     = 3'd3;
	localparam logic [2:0] CFG_BRIGHT_FLOOR    = 3'd4;

	// Configuration reset values
	localparam logic [6:0]  RST_UNITS_PER_PIXEL = 7'd4;
	localparam logic [15:0] RST_MSG_TIMEOUT     = 16'd2000;
	localparam logic [15:0] RST_REFRESH_PERIOD  = 16'd1000;
	localparam logic [7:0]  RST_BRIGHT_STEP     = 8'd25;
	localparam logic [7:0]  RST_BRIGHT_FLOOR    = 8'd20;
	localparam logic [7:0]  RST_BRIGHTNESS      = 8'd128;

	// Message format
	localparam logic [31:0] HEADER_MAGIC  = 32'h8081_7FFE;
	localparam logic [7:0]  AUTO_OFF_BYTE = 8'd255;
	localparam logic [8:0]  DIST_OFFSET   = 9'd127;
	localparam logic [15:0] AGE_MAX       = 16'hFFFF;

	// Divider: one quotient bit per step over the 7-bit error magnitude
	localparam int DIV_STEPS = 7;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // capture the accepted event
		logic apply;   // update state, start the divider
		logic emit;    // load the next pixel into the output register
	} glc_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic send;      // the applied event calls for a frame
		logic div_done;  // quotient is ready
		logic out_free;  // output register can take a pixel
		logic pix_last;  // next pixel is the final one of the frame
	} glc_status_t;

endpackage

[rtl/core/glc_ctrl.sv]
// ----------------------------------------------------------------------------
// glc_ctrl
// Sequencer of the lightbar core: accepts one event, has it applied, and for a
// frame waits for the bar level and steps it out one pixel at a time.
// ----------------------------------------------------------------------------
module glc_ctrl
	import glc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output glc_cmd_t    cmd,
	input  glc_status_t status
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_APPLY = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_EMIT  = 4'b1000
	} glc_state_t;

	glc_state_t state_q, state_d;

	// Take a transaction only between events
	assign in_stall  = (state_q != ST_IDLE);
	assign cmd.load  = in_valid && (state_q == ST_IDLE);
	assign cmd.apply = (state_q == ST_APPLY);
	assign cmd.emit  = (state_q == ST_EMIT) && status.out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				state_d = status.send ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (status.div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free && status.pix_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A pixel is never loaded before the level is known
	a_emit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.div_done)
		else $error("pixel emitted before divider finished");

	// Every apply is followed by a frame or a return to idle
	a_apply_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |=> (state_q == ST_DIV) || (state_q == ST_IDLE))
		else $error("bad state after apply");

	// Frame ends by going idle on the final pixel
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && status.pix_last |=> (state_q == ST_IDLE))
		else $error("frame did not end after final pixel");

endmodule

[rtl/core/glc_dp.sv]
// ----------------------------------------------------------------------------
// glc_dp
// Datapath of the lightbar core: configuration registers, status and error
// state, age counters, brightness, a bit-serial divider for the bar level
// and the pixel generator with its output register.
// ----------------------------------------------------------------------------
module glc_dp
	import glc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	// event payload
	input  logic [1:0]        op,
	input  logic              link_up,
	input  logic [31:0]       header_word,
	input  logic [7:0]        distance_byte,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  pixel_index,
	output logic [2:0]        pixel_colour,
	output logic [7:0]        brightness,
	output logic [1:0]        mode,
	output logic              frame_last,
	// controller link
	input  glc_cmd_t          cmd,
	output glc_status_t       status
);

	// Configuration
	logic [6:0]  upp_q;
	logic [15:0] timeout_q;
	logic [15:0] period_q;
	logic [7:0]  step_q;
	logic [7:0]  floor_q;

	// Captured event
	logic [1:0]  ev_op_q;
	logic        ev_up_q;
	logic [31:0] ev_hdr_q;
	logic [7:0]  ev_dist_q;

	// State
	logic [1:0]        mode_q, prev_mode_q;
	logic              link_q;
	logic signed [7:0] err_q, prev_err_q;
	logic [15:0]       msg_age_q, refresh_age_q;
	logic [7:0]        bright_q;

	// Next-state values of one event
	logic [1:0]        mode_n;
	logic              link_n;
	logic signed [7:0] err_n;
	logic [15:0]       msg_age_n, refresh_age_n;
	logic [7:0]        bright_n, bright_diff;
	logic [8:0]        dist_off;
	logic              send_n;

	// Divider
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [6:0]           quot_q, rem_q;
	logic [6:0]           divisor;
	logic [7:0]           err_mag_n;
	logic [8:0]           trial;

	// Pixel generator
	logic [PIX_W-1:0] pix_q;
	logic [LVL_W-1:0] lvl_mag;
	logic             lvl_neg;
	logic [PIX_W-1:0] lo_pix, hi_pix;
	logic [2:0]       colour_n;

	// Output register
	logic             out_valid_q;
	logic [PIX_W-1:0] out_idx_q;
	logic [2:0]       out_col_q;
	logic [7:0]       out_bright_q;
	logic [1:0]       out_mode_q;
	logic             out_last_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upp_q     <= RST_UNITS_PER_PIXEL;
			timeout_q <= RST_MSG_TIMEOUT;
			period_q  <= RST_REFRESH_PERIOD;
			step_q    <= RST_BRIGHT_STEP;
			floor_q   <= RST_BRIGHT_FLOOR;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UNITS_PER_PIXEL: upp_q     <= cfg_data[6:0];
				CFG_MSG_TIMEOUT:     timeout_q <= cfg_data;
				CFG_REFRESH_PERIOD:  period_q  <= cfg_data;
				CFG_BRIGHT_STEP:     step_q    <= cfg_data[7:0];
				CFG_BRIGHT_FLOOR:    floor_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Capture the accepted event
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ev_op_q   <= op;
			ev_up_q   <= link_up;
			ev_hdr_q  <= header_word;
			ev_dist_q <= distance_byte;
		end
	end

	// Apply the event, then the timeout, then the frame test
	always_comb begin
		mode_n        = mode_q;
		link_n        = link_q;
		err_n         = err_q;
		msg_age_n     = msg_age_q;
		refresh_age_n = refresh_age_q;
		bright_n      = bright_q;
		dist_off      = {1'b0, ev_dist_q} - DIST_OFFSET;
		bright_diff   = bright_q - step_q;
		case (ev_op_q)
			OP_LINK: begin
				if (ev_up_q != link_q) begin
					mode_n = ev_up_q ? MODE_NO_DATA : MODE_NO_LINK;
					link_n = ev_up_q;
				end
			end
			OP_MSG: begin
				if (link_q && (ev_hdr_q == HEADER_MAGIC)) begin
					msg_age_n = '0;
					if (ev_dist_q == AUTO_OFF_BYTE) begin
						err_n  = '0;
						mode_n = MODE_AUTO_OFF;
					end else begin
						err_n  = signed'(dist_off[7:0]);
						mode_n = MODE_GUIDING;
					end
				end
			end
			OP_TICK: begin
				if (msg_age_q != AGE_MAX) msg_age_n = msg_age_q + 16'd1;
				if (refresh_age_q != AGE_MAX) refresh_age_n = refresh_age_q + 16'd1;
			end
			OP_BUTTON: begin
				bright_n = (bright_diff < floor_q) ? floor_q : bright_diff;
			end
			default: ;
		endcase
		if (link_n && (msg_age_n > timeout_q)) mode_n = MODE_NO_DATA;
		send_n = (err_n != prev_err_q) || (mode_n != prev_mode_q) ||
			(refresh_age_n > period_q);
	end

	// Commit the event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_NO_LINK;
			prev_mode_q   <= MODE_NO_LINK;
			link_q        <= 1'b0;
			err_q         <= '0;
			prev_err_q    <= '0;
			msg_age_q     <= '0;
			refresh_age_q <= '0;
			bright_q      <= RST_BRIGHTNESS;
		end else if (cmd.apply) begin
			mode_q    <= mode_n;
			link_q    <= link_n;
			err_q     <= err_n;
			msg_age_q <= msg_age_n;
			bright_q  <= bright_n;
			if (send_n) begin
				refresh_age_q <= '0;
				prev_mode_q   <= mode_n;
				prev_err_q    <= err_n;
			end else begin
				refresh_age_q <= refresh_age_n;
			end
		end
	end

	// Divide the error magnitude by units per pixel, one bit per cycle
	assign err_mag_n = err_n[7] ? 8'(-err_n) : 8'(err_n);
	assign divisor   = (upp_q == '0) ? 7'd1 : upp_q;
	assign trial     = {1'b0, rem_q, quot_q[6]} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.apply) begin
			div_cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			quot_q <= err_mag_n[6:0];
			rem_q  <= '0;
		end else if (div_cnt_q != '0) begin
			if (!trial[8]) begin
				rem_q  <= trial[6:0];
				quot_q <= {quot_q[5:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[5:0], quot_q[6]};
				quot_q <= {quot_q[5:0], 1'b0};
			end
		end
	end

	// Clamp the level to the half width of the bar
	assign lvl_mag = (quot_q > 7'(CENTRE)) ? LVL_W'(CENTRE) : quot_q[LVL_W-1:0];
	assign lvl_neg = err_q[7];
	assign lo_pix  = CENTRE_PIX - PIX_W'(lvl_mag);
	assign hi_pix  = CENTRE_PIX + PIX_W'(lvl_mag);

	// Colour of the current pixel
	always_comb begin
		colour_n = COL_BLACK;
		if (mode_q == MODE_GUIDING) begin
			if (lvl_mag == '0) begin
				if (pix_q == CENTRE_PIX) colour_n = COL_YELLOW;
			end else if (lvl_neg) begin
				if ((pix_q >= lo_pix) && (pix_q < CENTRE_PIX)) colour_n = COL_GREEN;
			end else begin
				if ((pix_q > CENTRE_PIX) && (pix_q <= hi_pix)) colour_n = COL_RED;
			end
		end else if ((pix_q == '0) || (pix_q == LAST_PIX)) begin
			case (mode_q)
				MODE_NO_LINK: colour_n = COL_RED;
				MODE_NO_DATA: colour_n = COL_BLUE;
				default:      colour_n = COL_GREEN;
			endcase
		end
	end

	// Advance the pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (cmd.apply) begin
			pix_q <= '0;
		end else if (cmd.emit) begin
			pix_q <= pix_q + 1'b1;
		end
	end

	// Output register: load a pixel or drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_idx_q    <= pix_q;
			out_col_q    <= colour_n;
			out_bright_q <= bright_q;
			out_mode_q   <= mode_q;
			out_last_q   <= (pix_q == LAST_PIX);
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_index  = out_idx_q;
	assign pixel_colour = out_col_q;
	assign brightness   = out_bright_q;
	assign mode         = out_mode_q;
	assign frame_last   = out_last_q;

	// Status to the controller
	assign status.send     = send_n;
	assign status.div_done = (div_cnt_q == '0);
	assign status.out_free = !out_valid_q || !out_stall;
	assign status.pix_last = (pix_q == LAST_PIX);

	// A sent frame restarts the refresh age
	a_refresh_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && send_n |=> (refresh_age_q == '0) && (prev_mode_q == mode_q))
		else $error("frame decision not committed");

	// Pixel counter stays within the bar, or one past it once a frame is out
	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_q <= PIX_W'(NUM_PIXELS))
		else $error("pixel counter out of range");

	// The final pixel carries the frame end mark
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && (pix_q == LAST_PIX) |=> out_valid_q && out_last_q)
		else $error("final pixel lacks frame end mark");

endmodule

[rtl/core/guidance_lightbar_controller_core.sv]
// ----------------------------------------------------------------------------
// guidance_lightbar_controller_core
// Lightbar controller: tracks link, guidance messages, ms ticks and button
// presses, and sends a frame of pixel colours on a picture change or refresh.
// ----------------------------------------------------------------------------
// An event is taken when in_valid is high and in_stall is low. Every event
// is applied in the cycle after it is taken. When a frame is due, a
// bit-serial divider forms the bar level in 7 quotient steps and hands it
// over; then the frame leaves through the output register one pixel per
// cycle while out_stall is low, NUM_PIXELS pixels ending with frame_last.
// Configuration writes are taken at any time and should be made only while
// no event is in progress.
// ----------------------------------------------------------------------------
module guidance_lightbar_controller_core
	import glc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	// event channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic              link_up,
	input  logic [31:0]       header_word,
	input  logic [7:0]        distance_byte,
	// pixel channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  pixel_index,
	output logic [2:0]        pixel_colour,
	output logic [7:0]        brightness,
	output logic [1:0]        mode,
	output logic              frame_last
);

	glc_cmd_t    cmd;
	glc_status_t status;

	glc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	glc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.link_up       (link_up),
		.header_word   (header_word),
		.distance_byte (distance_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_index   (pixel_index),
		.pixel_colour  (pixel_colour),
		.brightness    (brightness),
		.mode          (mode),
		.frame_last    (frame_last),
		.cmd           (cmd),
		.status        (status)
	);

endmodule
